/* sv/ftc_pkg.sv */
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared field widths, codes and controller/datapath interface structs for
// the face-to-cell adjacency builder.
// ----------------------------------------------------------------------------
package ftc_pkg;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int CELL_W   = 10;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 13;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] CELL_COUNT_RST = 11'd1024;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RD_OFF   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_LIST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CELL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 3'd4;

    // Cursor memory read address source
    typedef enum logic [1:0] {
        CUR_NONE,
        CUR_LEFT,
        CUR_RIGHT,
        CUR_CELL
    } cur_sel_t;

    // Result value source
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_TOTAL,
        RES_OFF_Q,
        RES_ADJ_Q,
        RES_ACC
    } res_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                accept;
        logic                load_face;
        logic                clear_total;
        logic                built_set;
        logic                built_clr;
        logic                face_rd;
        logic                f_clr;
        logic                f_inc;
        logic                c_clr;
        logic                c_inc;
        cur_sel_t            cur_rd;
        logic                cur_wr_zero;
        logic                cur_wr_inc;
        logic                cur_wr_acc;
        logic                acc_clr;
        logic                acc_add;
        logic                off_wr;
        logic                off_rd_idx;
        logic                off_rd_n;
        logic                adj_wr;
        logic                adj_rd;
        logic                res_load;
        res_sel_t            res_sel;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_cell_bad;
        logic full;
        logic built;
        logic idx_gt_n;
        logic total_zero;
        logic f_last;
        logic c_top;
        logic c_end;
        logic face_bad;
        logic list_bad;
        logic out_free;
    } sts_t;

endpackage

/* sv/face_to_cell_adjacency_builder.sv */
// ----------------------------------------------------------------------------
// face_to_cell_adjacency_builder
// Builds compressed cell-to-face lists from loaded face/cell pairs.
// ----------------------------------------------------------------------------
// Loads and clears can follow back to back. Offset queries go through the
// registered read of the offset table, and list queries through the
// registered reads of the offset table and adjacency list. A build zeroes
// the count memory cell by cell, then runs a counting pass over the faces,
// a prefix sum over the cells and a scatter pass over the faces, all bound
// by the single read-modify-write port of the count memory. The input is
// held off while a build or query runs and while a result waits.
module face_to_cell_adjacency_builder import ftc_pkg::*; #(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_FACES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: cell_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_cell[9:0], right_cell[19:10], index[31:20]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value[12:0], zero fill[15:13]
    output logic [2:0]  m_tuser    // status[2:0]
);

    cmd_t               cmd;
    sts_t               sts;
    logic [VALUE_W-1:0] value;

    assign cfg_ready = 1'b1;

    ftc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_mode  (s_tuser),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ftc_dpath #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_FACES (MAX_FACES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_left   (s_tdata[9:0]),
        .in_right  (s_tdata[19:10]),
        .in_index  (s_tdata[31:20]),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_value   (value),
        .m_status  (m_tuser)
    );

    assign m_tdata = {3'b000, value};

`ifndef SYNTHESIS
    // An error result never carries a value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == 16'd0))
        else $error("error result with nonzero value");

    // A transaction is only taken when the result slot can take its result
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("input taken while result slot busy");

    // Result register loads only when free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> sts.out_free)
        else $error("result overwritten");
`endif

endmodule

/* sv/ftc_dpath.sv */
// ----------------------------------------------------------------------------
// ftc_dpath
// Face stores, count/cursor memory, offset table, adjacency list, counters,
// running sum and the result register.
// ----------------------------------------------------------------------------
module ftc_dpath import ftc_pkg::*; #(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_FACES = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CELL_W-1:0]    in_left,
    input  logic [CELL_W-1:0]    in_right,
    input  logic [INDEX_W-1:0]   in_index,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [VALUE_W-1:0]   m_value,
    output logic [STATUS_W-1:0]  m_status
);

    localparam int NW   = ($clog2(MAX_CELLS + 1) > CFG_W) ? $clog2(MAX_CELLS + 1) : CFG_W;
    localparam int OAW  = $clog2(MAX_CELLS + 1);
    localparam int CAW  = $clog2(MAX_CELLS);
    localparam int FAW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FTW  = $clog2(MAX_FACES + 1);
    localparam int OVW  = $clog2(2 * MAX_FACES + 1);
    localparam int AAW  = $clog2(2 * MAX_FACES);
    localparam int CMPW = ((NW > OVW) ? NW : OVW) + INDEX_W;

    // Configuration and control registers
    logic [CFG_W-1:0] cell_count_reg;
    logic [FTW-1:0]   face_total_reg;
    logic             built_reg;
    logic [FTW-1:0]   f_reg;
    logic [OAW-1:0]   c_reg;
    logic [OVW-1:0]   acc_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [CAW-1:0]   cur_addr_reg;

    // Memories and their registered read data
    logic [CELL_W-1:0] face_left_mem  [MAX_FACES];
    logic [CELL_W-1:0] face_right_mem [MAX_FACES];
    logic [OVW-1:0]    cur_mem        [MAX_CELLS];
    logic [OVW-1:0]    off_mem        [MAX_CELLS + 1];
    logic [FAW-1:0]    adj_mem        [2 * MAX_FACES];

    logic [CELL_W-1:0] face_l_q_reg;
    logic [CELL_W-1:0] face_r_q_reg;
    logic [OVW-1:0]    cur_q_reg;
    logic [OVW-1:0]    off_q_reg;
    logic [FAW-1:0]    adj_q_reg;

    // Result register
    logic                res_valid_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic [NW-1:0]  n_eff;
    logic [CAW-1:0] cur_rd_addr;
    logic [CAW-1:0] cur_wr_addr;
    logic [OVW-1:0] cur_wr_data;
    logic [OVW-1:0] off_wr_data;
    logic [VALUE_W-1:0] res_value_next;

    // Effective cell count
    assign n_eff = (NW'(cell_count_reg) < NW'(MAX_CELLS)) ? NW'(cell_count_reg)
                                                          : NW'(MAX_CELLS);

    // Status toward the controller
    always_comb begin
        sts.in_cell_bad = (CMPW'(in_left) >= CMPW'(n_eff)) ||
                          (CMPW'(in_right) >= CMPW'(n_eff));
        sts.full        = (face_total_reg >= FTW'(MAX_FACES));
        sts.built       = built_reg;
        sts.idx_gt_n    = (CMPW'(in_index) > CMPW'(n_eff));
        sts.total_zero  = (face_total_reg == '0);
        sts.f_last      = ((f_reg + FTW'(1)) == face_total_reg);
        sts.c_top       = (c_reg == OAW'(MAX_CELLS - 1));
        sts.c_end       = (c_reg == OAW'(MAX_CELLS));
        sts.face_bad    = (CMPW'(face_l_q_reg) >= CMPW'(n_eff)) ||
                          (CMPW'(face_r_q_reg) >= CMPW'(n_eff));
        sts.list_bad    = (CMPW'(idx_reg) >= CMPW'(off_q_reg)) ||
                          (CMPW'(idx_reg) >= CMPW'(2 * MAX_FACES));
        sts.out_free    = !res_valid_reg || m_ready;
    end

    // Cursor memory address and data selection
    always_comb begin
        case (cmd.cur_rd)
            CUR_LEFT:  cur_rd_addr = CAW'(face_l_q_reg);
            CUR_RIGHT: cur_rd_addr = CAW'(face_r_q_reg);
            CUR_CELL:  cur_rd_addr = CAW'(c_reg);
            default:   cur_rd_addr = cur_addr_reg;
        endcase
        if (cmd.cur_wr_inc) begin
            cur_wr_addr = cur_addr_reg;
            cur_wr_data = cur_q_reg + OVW'(1);
        end else if (cmd.cur_wr_acc) begin
            cur_wr_addr = CAW'(c_reg);
            cur_wr_data = acc_reg;
        end else begin
            cur_wr_addr = CAW'(c_reg);
            cur_wr_data = '0;
        end
        off_wr_data = (NW'(c_reg) <= n_eff) ? acc_reg : '0;
    end

    // Result value selection
    always_comb begin
        case (cmd.res_sel)
            RES_TOTAL: res_value_next = VALUE_W'(face_total_reg);
            RES_OFF_Q: res_value_next = VALUE_W'(off_q_reg);
            RES_ADJ_Q: res_value_next = VALUE_W'(adj_q_reg);
            RES_ACC:   res_value_next = VALUE_W'(acc_reg);
            default:   res_value_next = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg <= CELL_COUNT_RST;
            face_total_reg <= '0;
            built_reg      <= 1'b0;
            f_reg          <= '0;
            c_reg          <= '0;
            acc_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cell_count_reg <= cfg_data;
            end
            if (cmd.clear_total) begin
                face_total_reg <= '0;
            end else if (cmd.load_face) begin
                face_total_reg <= face_total_reg + FTW'(1);
            end
            if (cmd.built_set) begin
                built_reg <= 1'b1;
            end else if (cmd.built_clr || cmd.load_face) begin
                built_reg <= 1'b0;
            end
            if (cmd.f_clr) begin
                f_reg <= '0;
            end else if (cmd.f_inc) begin
                f_reg <= f_reg + FTW'(1);
            end
            if (cmd.c_clr) begin
                c_reg <= '0;
            end else if (cmd.c_inc) begin
                c_reg <= c_reg + OAW'(1);
            end
            if (cmd.acc_clr) begin
                acc_reg <= '0;
            end else if (cmd.acc_add) begin
                acc_reg <= acc_reg + cur_q_reg;
            end
            if (cmd.res_load) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg <= in_index;
        end
        if (cmd.res_load) begin
            res_value_reg  <= res_value_next;
            res_status_reg <= cmd.res_status;
        end
    end

    // Face stores
    always_ff @(posedge aclk) begin
        if (cmd.load_face) begin
            face_left_mem[FAW'(face_total_reg)]  <= in_left;
            face_right_mem[FAW'(face_total_reg)] <= in_right;
        end
        if (cmd.face_rd) begin
            face_l_q_reg <= face_left_mem[FAW'(f_reg)];
            face_r_q_reg <= face_right_mem[FAW'(f_reg)];
        end
    end

    // Count / cursor memory
    always_ff @(posedge aclk) begin
        if (cmd.cur_wr_zero || cmd.cur_wr_inc || cmd.cur_wr_acc) begin
            cur_mem[cur_wr_addr] <= cur_wr_data;
        end
        if (cmd.cur_rd != CUR_NONE) begin
            cur_q_reg    <= cur_mem[cur_rd_addr];
            cur_addr_reg <= cur_rd_addr;
        end
    end

    // Offset table
    always_ff @(posedge aclk) begin
        if (cmd.off_wr) begin
            off_mem[c_reg] <= off_wr_data;
        end
        if (cmd.off_rd_idx) begin
            off_q_reg <= off_mem[OAW'(in_index)];
        end else if (cmd.off_rd_n) begin
            off_q_reg <= off_mem[OAW'(n_eff)];
        end
    end

    // Adjacency list
    always_ff @(posedge aclk) begin
        if (cmd.adj_wr) begin
            adj_mem[AAW'(cur_q_reg)] <= FAW'(f_reg);
        end
        if (cmd.adj_rd) begin
            adj_q_reg <= adj_mem[AAW'(idx_reg)];
        end
    end

    assign m_valid  = res_valid_reg;
    assign m_value  = res_value_reg;
    assign m_status = res_status_reg;

endmodule

/* sv/ftc_ctrl.sv */
// ----------------------------------------------------------------------------
// ftc_ctrl
// Sequencer: decodes items, runs the build passes (zero, count, prefix sum,
// scatter) and the offset and list queries.
// ----------------------------------------------------------------------------
module ftc_ctrl import ftc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [MODE_W-1:0] s_mode,
    output logic              s_ready,
    input  sts_t              sts,
    output cmd_t              cmd
);

    typedef enum logic [4:0] {
        IDLE,
        RO_OUT,
        RL_CHK,
        RL_OUT,
        ZERO,
        CNT_F,
        CNT_CHK,
        CNT_LW,
        CNT_R,
        CNT_RW,
        PRE_RD,
        PRE_WR,
        SC_F,
        SC_L,
        SC_LW,
        SC_R,
        SC_RW,
        BLD_DONE,
        BLD_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == IDLE) && sts.out_free;

    // Command decode and next state
    always_comb begin
        cmd            = '0;
        cmd.cur_rd     = CUR_NONE;
        cmd.res_sel    = RES_ZERO;
        cmd.res_status = ST_OK;
        state_next     = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    case (s_mode)
                        MODE_LOAD: begin
                            cmd.res_load = 1'b1;
                            if (sts.in_cell_bad) begin
                                cmd.res_status = ST_BAD_CELL;
                            end else if (sts.full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.load_face = 1'b1;
                                cmd.res_sel   = RES_TOTAL;
                            end
                        end
                        MODE_BUILD: begin
                            cmd.c_clr   = 1'b1;
                            cmd.f_clr   = 1'b1;
                            cmd.acc_clr = 1'b1;
                            state_next  = ZERO;
                        end
                        MODE_RD_OFF: begin
                            if (!sts.built) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NOT_BUILT;
                            end else if (sts.idx_gt_n) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_BAD_INDEX;
                            end else begin
                                cmd.off_rd_idx = 1'b1;
                                state_next     = RO_OUT;
                            end
                        end
                        MODE_RD_LIST: begin
                            if (!sts.built) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NOT_BUILT;
                            end else begin
                                cmd.off_rd_n = 1'b1;
                                state_next   = RL_CHK;
                            end
                        end
                        MODE_CLEAR: begin
                            cmd.clear_total = 1'b1;
                            cmd.built_clr   = 1'b1;
                            cmd.res_load    = 1'b1;
                        end
                        default: begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            RO_OUT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_OFF_Q;
                    state_next   = IDLE;
                end
            end
            RL_CHK: begin
                if (sts.list_bad) begin
                    if (sts.out_free) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_BAD_INDEX;
                        state_next     = IDLE;
                    end
                end else begin
                    cmd.adj_rd = 1'b1;
                    state_next = RL_OUT;
                end
            end
            RL_OUT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ADJ_Q;
                    state_next   = IDLE;
                end
            end
            // Clear the count memory, one cell a cycle
            ZERO: begin
                cmd.cur_wr_zero = 1'b1;
                cmd.c_inc       = 1'b1;
                if (sts.c_top) begin
                    cmd.c_clr  = 1'b1;
                    state_next = sts.total_zero ? PRE_RD : CNT_F;
                end
            end
            // Count pass with cell range check
            CNT_F: begin
                cmd.face_rd = 1'b1;
                state_next  = CNT_CHK;
            end
            CNT_CHK: begin
                if (sts.face_bad) begin
                    state_next = BLD_ERR;
                end else begin
                    cmd.cur_rd = CUR_LEFT;
                    state_next = CNT_LW;
                end
            end
            CNT_LW: begin
                cmd.cur_wr_inc = 1'b1;
                state_next     = CNT_R;
            end
            CNT_R: begin
                cmd.cur_rd = CUR_RIGHT;
                state_next = CNT_RW;
            end
            CNT_RW: begin
                cmd.cur_wr_inc = 1'b1;
                cmd.f_inc      = 1'b1;
                state_next     = sts.f_last ? PRE_RD : CNT_F;
            end
            // Prefix sum: offsets and scatter cursors
            PRE_RD: begin
                if (sts.c_end) begin
                    cmd.off_wr = 1'b1;
                    cmd.f_clr  = 1'b1;
                    state_next = sts.total_zero ? BLD_DONE : SC_F;
                end else begin
                    cmd.cur_rd = CUR_CELL;
                    state_next = PRE_WR;
                end
            end
            PRE_WR: begin
                cmd.off_wr     = 1'b1;
                cmd.cur_wr_acc = 1'b1;
                cmd.acc_add    = 1'b1;
                cmd.c_inc      = 1'b1;
                state_next     = PRE_RD;
            end
            // Scatter face numbers in load order
            SC_F: begin
                cmd.face_rd = 1'b1;
                state_next  = SC_L;
            end
            SC_L: begin
                cmd.cur_rd = CUR_LEFT;
                state_next = SC_LW;
            end
            SC_LW: begin
                cmd.adj_wr     = 1'b1;
                cmd.cur_wr_inc = 1'b1;
                state_next     = SC_R;
            end
            SC_R: begin
                cmd.cur_rd = CUR_RIGHT;
                state_next = SC_RW;
            end
            SC_RW: begin
                cmd.adj_wr     = 1'b1;
                cmd.cur_wr_inc = 1'b1;
                cmd.f_inc      = 1'b1;
                state_next     = sts.f_last ? BLD_DONE : SC_F;
            end
            BLD_DONE: begin
                if (sts.out_free) begin
                    cmd.built_set = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = RES_ACC;
                    state_next    = IDLE;
                end
            end
            BLD_ERR: begin
                if (sts.out_free) begin
                    cmd.built_clr  = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_BAD_CELL;
                    state_next     = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* bench/tb_face_to_cell_adjacency_builder.sv */
// ----------------------------------------------------------------------------
// tb_face_to_cell_adjacency_builder
// Self-checking bench: streams face loads, builds, offset/list queries and
// clears into the block, predicts every result with a software adjacency
// model and compares status and value per transaction.
// ----------------------------------------------------------------------------
module tb_face_to_cell_adjacency_builder;
    import ftc_pkg::*;

    localparam int N_CELLS = 1024;
    localparam int N_FACES = 2048;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [CELL_W-1:0]  left;
        logic [CELL_W-1:0]  right;
        logic [INDEX_W-1:0] index;
    } face_item_t;

    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } face_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    face_to_cell_adjacency_builder dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Stimulus and expectation stores
    face_item_t   pending_items[$];
    face_result_t expected_results[$];
    face_item_t   cur_item;

    // Adjacency model state
    logic [CELL_W-1:0] mdl_left[N_FACES];
    logic [CELL_W-1:0] mdl_right[N_FACES];
    int                mdl_face_total;
    int                mdl_offset[N_CELLS+1];
    int                mdl_fill[N_CELLS];
    int                mdl_adj[2*N_FACES];
    bit                mdl_built;
    int                mdl_cell_count;

    // Bench control
    int tx_idle_pct, rx_idle_pct;
    bit cfg_pending;
    logic [10:0] cfg_next;
    bit hold_go;
    int hold_cycles;
    int mismatches, n_items, n_results, n_builds, n_cfg;
    int cfg_now;

    function automatic int eff_cells();
        return (mdl_cell_count < N_CELLS) ? mdl_cell_count : N_CELLS;
    endfunction

    function automatic logic [STATUS_W-1:0] build_adjacency();
        int n, f, c, pos;
        n = eff_cells();
        for (f = 0; f < mdl_face_total; f++)
            if (mdl_left[f] >= n || mdl_right[f] >= n) return ST_BAD_CELL;
        for (c = 0; c <= N_CELLS; c++) mdl_offset[c] = 0;
        for (c = 0; c < N_CELLS; c++) mdl_fill[c] = 0;
        for (f = 0; f < mdl_face_total; f++) begin
            mdl_offset[mdl_left[f]+1]++;
            mdl_offset[mdl_right[f]+1]++;
        end
        for (c = 0; c < n; c++) mdl_offset[c+1] += mdl_offset[c];
        for (f = 0; f < mdl_face_total; f++) begin
            pos = mdl_offset[mdl_left[f]] + mdl_fill[mdl_left[f]];
            mdl_fill[mdl_left[f]]++;
            if (pos < 2*N_FACES) mdl_adj[pos] = f;
            pos = mdl_offset[mdl_right[f]] + mdl_fill[mdl_right[f]];
            mdl_fill[mdl_right[f]]++;
            if (pos < 2*N_FACES) mdl_adj[pos] = f;
        end
        mdl_built = 1;
        return ST_OK;
    endfunction

    // Expected result of one accepted item; updates the model
    function automatic face_result_t predict_adjacency(face_item_t it);
        face_result_t r;
        int n, c;
        logic [STATUS_W-1:0] st;
        n = eff_cells();
        r.value = '0;
        r.status = ST_OK;
        case (it.mode)
            MODE_LOAD: begin
                if (it.left >= n || it.right >= n) r.status = ST_BAD_CELL;
                else if (mdl_face_total >= N_FACES) r.status = ST_FULL;
                else begin
                    mdl_left[mdl_face_total] = it.left;
                    mdl_right[mdl_face_total] = it.right;
                    mdl_built = 0;
                    r.value = VALUE_W'(mdl_face_total);
                    mdl_face_total++;
                end
            end
            MODE_BUILD: begin
                st = build_adjacency();
                if (st != ST_OK) begin
                    mdl_built = 0;
                    r.status = st;
                end else r.value = VALUE_W'(mdl_offset[n]);
            end
            MODE_RD_OFF: begin
                if (!mdl_built) r.status = ST_NOT_BUILT;
                else if (it.index > n) r.status = ST_BAD_INDEX;
                else r.value = VALUE_W'(mdl_offset[it.index]);
            end
            MODE_RD_LIST: begin
                if (!mdl_built) r.status = ST_NOT_BUILT;
                else if (it.index >= mdl_offset[n] || it.index >= 2*N_FACES)
                    r.status = ST_BAD_INDEX;
                else r.value = VALUE_W'(mdl_adj[it.index]);
            end
            MODE_CLEAR: begin
                mdl_face_total = 0;
                for (c = 0; c <= N_CELLS; c++) mdl_offset[c] = 0;
                for (c = 0; c < N_CELLS; c++) mdl_fill[c] = 0;
                mdl_built = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Clock
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Input driver: predicts each accepted transaction, then offers the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_adjacency(cur_item));
                n_items++;
                if (cur_item.mode == MODE_BUILD) n_builds++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {cur_item.index, cur_item.right, cur_item.left};
                    s_tuser <= cur_item.mode;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Configuration channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 0;
        end else if (cfg_valid && cfg_ready) begin
            mdl_cell_count = cfg_data;
            cfg_valid <= 0;
            cfg_pending = 0;
            n_cfg++;
        end else if (cfg_pending && !cfg_valid) begin
            cfg_valid <= 1;
            cfg_data <= cfg_next;
        end
    end

    // Receiver hold-off counter
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_cycles <= 400;
            hold_go <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        face_result_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%0d status=%0d",
                                 m_tdata[12:0], m_tuser);
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[12:0] !== e.value || m_tuser !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                                     e.value, e.status, m_tdata[12:0], m_tuser);
                    end
                end
            end
            m_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic push_item(int mode, int l, int r, int idx);
        face_item_t it;
        it.mode = MODE_W'(mode);
        it.left = CELL_W'(l);
        it.right = CELL_W'(r);
        it.index = INDEX_W'(idx);
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cell_count(int v);
        wait_idle();
        cfg_next = 11'(v);
        cfg_now = v;
        cfg_pending = 1;
        wait (!cfg_pending);
        @(posedge aclk);
    endtask

    function automatic int good_cell(int eff);
        return (eff > 0) ? $urandom_range(0, eff - 1) : 0;
    endfunction

    // One well-formed load/build/query run with some noise mixed in
    task automatic push_sequence();
        int eff, k, q, i, sel;
        eff = (cfg_now < N_CELLS) ? cfg_now : N_CELLS;
        if ($urandom_range(0, 9) < 7) push_item(MODE_CLEAR, $urandom, $urandom, $urandom);
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
        for (i = 0; i < k; i++) begin
            push_item(MODE_LOAD, good_cell(eff), good_cell(eff), $urandom);
            sel = $urandom_range(0, 14);
            if (sel == 0)
                push_item(MODE_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
            else if (sel == 1)
                push_item($urandom_range(5, 7), $urandom, $urandom, $urandom);
            else if (sel == 2)
                push_item($urandom_range(MODE_RD_OFF, MODE_RD_LIST), 0, 0,
                          $urandom_range(0, 4095));
        end
        push_item(MODE_BUILD, $urandom, $urandom, $urandom);
        q = $urandom_range(4, 14);
        for (i = 0; i < q; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                push_item(MODE_RD_OFF, $urandom, $urandom, $urandom_range(0, eff + 1));
            else if (sel < 9)
                push_item(MODE_RD_LIST, $urandom, $urandom, $urandom_range(0, 2 * k + 1));
            else
                push_item($urandom_range(MODE_RD_OFF, MODE_RD_LIST), 0, 0,
                          $urandom_range(0, 4095));
        end
    endtask

    // Main sequence
    initial begin
        int i, phase;
        int cfg_set[8];
        cfg_set = '{1, 2, 37, 512, 1023, 1024, 2047, 0};
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        cfg_pending = 0;
        hold_go = 0;
        hold_cycles = 0;
        tx_idle_pct = 26;
        rx_idle_pct = 51;
        mismatches = 0;
        n_items = 0;
        n_results = 0;
        n_builds = 0;
        n_cfg = 0;
        mdl_face_total = 0;
        mdl_built = 0;
        mdl_cell_count = CELL_COUNT_RST;
        cfg_now = CELL_COUNT_RST;
        for (i = 0; i <= N_CELLS; i++) mdl_offset[i] = 0;
        for (i = 0; i < N_CELLS; i++) mdl_fill[i] = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // Directed: queries before build, empty build, odd modes, extremes
        push_item(MODE_RD_OFF, 0, 0, 0);
        push_item(MODE_RD_LIST, 0, 0, 0);
        push_item(MODE_BUILD, 0, 0, 0);
        push_item(MODE_RD_OFF, 0, 0, 0);
        push_item(MODE_RD_LIST, 0, 0, 0);
        push_item(5, 1023, 1023, 4095);
        push_item(6, 0, 0, 0);
        push_item(7, 1023, 0, 2048);
        push_item(MODE_LOAD, 0, 0, 0);
        push_item(MODE_LOAD, 1023, 1023, 4095);
        push_item(MODE_LOAD, 0, 1023, 0);
        push_item(MODE_BUILD, 0, 0, 0);
        push_item(MODE_RD_OFF, 0, 0, 1024);
        push_item(MODE_RD_OFF, 0, 0, 1025);
        push_item(MODE_RD_OFF, 0, 0, 4095);
        push_item(MODE_RD_LIST, 0, 0, 5);
        push_item(MODE_RD_LIST, 0, 0, 6);
        push_item(MODE_LOAD, 3, 3, 0);
        push_item(MODE_RD_OFF, 0, 0, 1);
        write_cell_count(2);
        // lowered cell count with stored faces: build must refuse
        push_item(MODE_LOAD, 2, 0, 0);
        push_item(MODE_BUILD, 0, 0, 0);
        push_item(MODE_RD_LIST, 0, 0, 0);
        push_item(MODE_CLEAR, 0, 0, 0);
        push_item(MODE_LOAD, 1, 1, 0);
        push_item(MODE_BUILD, 0, 0, 0);
        push_item(MODE_RD_OFF, 0, 0, 2);
        push_item(MODE_RD_OFF, 0, 0, 3);

        // Long load run with the receiver held off early on
        write_cell_count(1024);
        push_item(MODE_CLEAR, 0, 0, 0);
        hold_go = 1;
        for (i = 0; i < 150; i++)
            push_item(MODE_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        push_item(MODE_LOAD, 5, 6, 0);
        push_item(MODE_LOAD, 1023, 0, 0);
        write_cell_count(1000);
        push_item(MODE_LOAD, 1010, 0, 0);
        write_cell_count(1024);
        push_item(MODE_BUILD, 0, 0, 0);
        push_item(MODE_RD_OFF, 0, 0, 1024);
        push_item(MODE_RD_LIST, 0, 0, 4095);
        push_item(MODE_RD_LIST, 0, 0, 0);
        push_item(MODE_RD_LIST, 0, 0, 2047);
        push_item(MODE_CLEAR, 0, 0, 0);

        // Random runs over three idling regimes
        for (phase = 0; phase < 3; phase++) begin
            wait_idle();
            tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 51 : 0;
            rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 26 : 0;
            i = n_items + pending_items.size();
            while (n_items + pending_items.size() - i < 250) begin
                if ($urandom_range(0, 3) == 0)
                    write_cell_count(cfg_set[$urandom_range(0, 7)]);
                else if ($urandom_range(0, 7) == 0)
                    write_cell_count($urandom_range(1, 1024));
                push_sequence();
                if (pending_items.size() > 0 && phase == 2 && $urandom_range(0, 5) == 0)
                    hold_go = 1;
                wait (pending_items.size() < 4);
            end
        end

        // Drain
        wait_idle();
        repeat (20) @(posedge aclk);
        $display("run covered %0d items, %0d results, %0d builds, %0d cell_count writes",
                 n_items, n_results, n_builds, n_cfg);
        $display("%0d mismatches, %0d results still outstanding",
                 mismatches, expected_results.size());
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Timeout
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/ftc_pkg.sv
sv/ftc_dpath.sv
sv/ftc_ctrl.sv
sv/face_to_cell_adjacency_builder.sv
bench/tb_face_to_cell_adjacency_builder.sv
